@@ rtl/core/bb3_pkg.sv @@
`default_nettype none
// Shared constants, types and a helper function of the 3x3 box blur core.
package bb3_pkg;

   localparam int MaxWidth = 1024;
   localparam int MaxHeight = 4096;

   localparam int PixW = 8;
   localparam int ColW = $clog2(MaxWidth);
   localparam int RowW = $clog2(MaxHeight);
   localparam int WidthCfgW = ColW + 1;
   localparam int HeightCfgW = RowW + 1;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = HeightCfgW;

   localparam int WidthReset = 600;
   localparam int HeightReset = 400;

   localparam logic [CsrIndexW-1:0] CsrFrameWidth = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrFrameHeight = 2'd1;

   localparam int WinDepth = 6;
   localparam int SumW = 12;
   localparam int BlurW = 16;
   localparam int NumRes = 4;
   localparam int ResIdxW = 2;

   // Results of one pixel, in delivery order.
   localparam int ResAboveLeft = 0;
   localparam int ResAboveEdge = 1;
   localparam int ResLastLeft = 2;
   localparam int ResLastEdge = 3;

   // floor(sum * 256 / 9) equals (sum * Recip9) >> RecipShift for every sum of nine pixels.
   localparam int RecipW = 21;
   localparam int RecipShift = 16;
   localparam logic [RecipW-1:0] Recip9 = 21'd1864136;

   typedef struct packed {
      logic [PixW-1:0] pixel;
      logic [ColW-1:0] col;
      logic [RowW-1:0] row;
      logic            last_col;
      logic            last_row;
   } item_type;

   typedef struct packed {
      logic [NumRes-1:0][SumW-1:0] sums;
      logic [NumRes-1:0]           mask;
      logic [ColW-1:0]             col;
      logic [RowW-1:0]             row;
   } run_type;

   function automatic logic [SumW-1:0] widen(input logic [PixW-1:0] value);
      return {{(SumW - PixW){1'b0}}, value};
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/bb3_ram.sv @@
`default_nettype none
// Generic simple dual-port RAM with one write port and one registered read port.
module bb3_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/bb3_window.sv @@
`default_nettype none
// Column stage: line memory read-back with forwarding, pixel window, column sums and write-back.
module bb3_window (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          restart,
   input  wire                          in_fire,
   input  wire bb3_pkg::item_type       in_item,
   input  wire [bb3_pkg::PixW-1:0]      older_rd_data,
   input  wire [bb3_pkg::PixW-1:0]      newer_rd_data,
   input  wire                          run_free,
   output logic                         in_stall,
   output logic                         wr_en,
   output logic [bb3_pkg::ColW-1:0]     wr_addr,
   output logic [bb3_pkg::PixW-1:0]     older_wr_data,
   output logic [bb3_pkg::PixW-1:0]     newer_wr_data,
   output logic                         run_valid,
   output bb3_pkg::run_type             run
);

   import bb3_pkg::*;

   logic                             s1_valid_ff, s1_valid_in;
   item_type                         s1_item_ff, s1_item_in;
   logic                             s1_fwd_ff, s1_fwd_in;
   logic [PixW-1:0]                  fwd_older_ff, fwd_older_in;
   logic [PixW-1:0]                  fwd_newer_ff, fwd_newer_in;
   logic [WinDepth-1:0][PixW-1:0]    win_ff, win_in;
   logic [WinDepth-1:0][PixW-1:0]    win_eff;
   logic [PixW-1:0]                  top_px, mid_px, bot_px;
   logic [SumW-1:0]                  a0, a1, a2, b0, b1, b2;
   logic                             s1_fire;

   always_comb begin
      bot_px = s1_item_ff.pixel;
      if (s1_item_ff.row == '0) begin
         top_px = s1_item_ff.pixel;
         mid_px = s1_item_ff.pixel;
      end else if (s1_fwd_ff) begin
         top_px = fwd_older_ff;
         mid_px = fwd_newer_ff;
      end else begin
         top_px = older_rd_data;
         mid_px = newer_rd_data;
      end
      if (s1_item_ff.col == '0) begin
         win_eff = {bot_px, mid_px, top_px, bot_px, mid_px, top_px};
      end else begin
         win_eff = win_ff;
      end
   end

   always_comb begin
      a0 = widen(top_px) + widen(mid_px) + widen(bot_px);
      a1 = widen(win_eff[0]) + widen(win_eff[1]) + widen(win_eff[2]);
      a2 = widen(win_eff[3]) + widen(win_eff[4]) + widen(win_eff[5]);
      b0 = widen(mid_px) + (widen(bot_px) << 1);
      b1 = widen(win_eff[1]) + (widen(win_eff[2]) << 1);
      b2 = widen(win_eff[4]) + (widen(win_eff[5]) << 1);

      run.sums[ResAboveLeft] = a2 + a1 + a0;
      run.sums[ResAboveEdge] = a1 + (a0 << 1);
      run.sums[ResLastLeft]  = b2 + b1 + b0;
      run.sums[ResLastEdge]  = b1 + (b0 << 1);

      run.mask[ResAboveLeft] = (s1_item_ff.row != '0) && (s1_item_ff.col != '0);
      run.mask[ResAboveEdge] = (s1_item_ff.row != '0) && s1_item_ff.last_col;
      run.mask[ResLastLeft]  = s1_item_ff.last_row && (s1_item_ff.col != '0);
      run.mask[ResLastEdge]  = s1_item_ff.last_row && s1_item_ff.last_col;

      run.col = s1_item_ff.col;
      run.row = s1_item_ff.row;
   end

   assign s1_fire = s1_valid_ff && ((run.mask == '0) || run_free);
   assign in_stall = s1_valid_ff && !s1_fire;
   assign run_valid = s1_fire && (run.mask != '0);

   assign wr_en = s1_fire;
   assign wr_addr = s1_item_ff.col;
   assign older_wr_data = mid_px;
   assign newer_wr_data = s1_item_ff.pixel;

   always_comb begin
      s1_valid_in = in_fire || (s1_valid_ff && !s1_fire);
      s1_item_in = s1_item_ff;
      s1_fwd_in = s1_fwd_ff;
      fwd_older_in = fwd_older_ff;
      fwd_newer_in = fwd_newer_ff;
      if (in_fire) begin
         // The read issued now misses a write to the same entry at this same edge.
         s1_item_in = in_item;
         s1_fwd_in = s1_fire && (in_item.col == s1_item_ff.col);
         fwd_older_in = mid_px;
         fwd_newer_in = s1_item_ff.pixel;
      end
      win_in = win_ff;
      if (restart) begin
         win_in = '0;
      end else if (s1_fire) begin
         win_in = {win_eff[2], win_eff[1], win_eff[0], bot_px, mid_px, top_px};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff <= 1'b0;
         win_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_fwd_ff <= s1_fwd_in;
         win_ff <= win_in;
      end
      s1_item_ff <= s1_item_in;
      fwd_older_ff <= fwd_older_in;
      fwd_newer_ff <= fwd_newer_in;
   end

   a_take_only_when_free: assert property (@(posedge clock) disable iff (reset)
      in_fire |-> (!s1_valid_ff || s1_fire))
      else $error("Pixel taken while the column stage was held.");

   a_forward_on_same_entry: assert property (@(posedge clock) disable iff (reset)
      (in_fire && s1_fire && (in_item.col == s1_item_ff.col)) |=> s1_fwd_ff)
      else $error("Same-entry write was not forwarded to the following read.");

endmodule
`default_nettype wire

@@ rtl/core/bb3_emit.sv @@
`default_nettype none
// Result stage: holds the results of one pixel, scales each sum by 256/9 and drives the output register.
module bb3_emit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          run_valid,
   input  wire bb3_pkg::run_type        run,
   output logic                         run_free,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [bb3_pkg::BlurW-1:0]    rsp_blurred,
   output logic [bb3_pkg::ColW-1:0]     rsp_out_col,
   output logic [bb3_pkg::RowW-1:0]     rsp_out_row,
   output logic                         rsp_last_of_run,
   output logic                         rsp_end_of_frame
);

   import bb3_pkg::*;

   logic                     buf_valid_ff, buf_valid_in;
   run_type                  buf_ff, buf_in;
   logic [NumRes-1:0]        buf_mask_ff, buf_mask_in;
   logic                     out_valid_ff, out_valid_in;
   logic [BlurW-1:0]         out_blurred_ff, out_blurred_in;
   logic [ColW-1:0]          out_col_ff, out_col_in;
   logic [RowW-1:0]          out_row_ff, out_row_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_eof_ff, out_eof_in;

   logic [ResIdxW-1:0]       cur_idx;
   logic [NumRes-1:0]        remaining;
   logic                     is_last;
   logic                     out_free;
   logic                     move;
   logic [SumW+RecipW-1:0]   product;

   always_comb begin
      priority if (buf_mask_ff[ResAboveLeft]) begin
         cur_idx = ResIdxW'(ResAboveLeft);
      end else if (buf_mask_ff[ResAboveEdge]) begin
         cur_idx = ResIdxW'(ResAboveEdge);
      end else if (buf_mask_ff[ResLastLeft]) begin
         cur_idx = ResIdxW'(ResLastLeft);
      end else begin
         cur_idx = ResIdxW'(ResLastEdge);
      end
   end

   assign remaining = buf_mask_ff & ~(NumRes'(1) << cur_idx);
   assign is_last = (remaining == '0);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign move = buf_valid_ff && out_free;
   assign run_free = !buf_valid_ff || (move && is_last);

   assign product = {{RecipW{1'b0}}, buf_ff.sums[cur_idx]} * {{SumW{1'b0}}, Recip9};

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_in = buf_ff;
      buf_mask_in = buf_mask_ff;
      if (run_valid) begin
         buf_valid_in = 1'b1;
         buf_in = run;
         buf_mask_in = run.mask;
      end else if (move) begin
         buf_valid_in = !is_last;
         buf_mask_in = remaining;
      end

      out_valid_in = out_valid_ff;
      out_blurred_in = out_blurred_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_last_in = out_last_ff;
      out_eof_in = out_eof_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_blurred_in = product[RecipShift +: BlurW];
         // Edge results sit on the current column, the others one column to the left.
         out_col_in = cur_idx[0] ? buf_ff.col : buf_ff.col - ColW'(1);
         out_row_in = cur_idx[1] ? buf_ff.row : buf_ff.row - RowW'(1);
         out_last_in = is_last;
         out_eof_in = (cur_idx == ResIdxW'(ResLastEdge));
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         out_valid_ff <= out_valid_in;
      end
      buf_ff <= buf_in;
      buf_mask_ff <= buf_mask_in;
      out_blurred_ff <= out_blurred_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
      out_last_ff <= out_last_in;
      out_eof_ff <= out_eof_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_blurred = out_blurred_ff;
   assign rsp_out_col = out_col_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_end_of_frame = out_eof_ff;

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      run_valid |-> run_free)
      else $error("New results arrived while the result buffer was still busy.");

   a_buffer_not_empty: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff |-> (buf_mask_ff != '0))
      else $error("Result buffer marked valid with no result left.");

   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_of_frame) |-> rsp_last_of_run)
      else $error("Final pixel of the frame is not the last result of its pixel.");

endmodule
`default_nettype wire

@@ rtl/core/box_blur_3x3_clamped_core.sv @@
`default_nettype none
// Top level of the 3x3 box blur with replicated borders: configuration, raster counters, line memories.
// A result reaches rsp through the column-stage register, the result buffer and the output register.
// Throughput: one pixel per cycle while each pixel causes at most one result and rsp is not stalled;
// a pixel that causes more than one result (right edge, last row) holds the input while the one
// result port delivers them. Line memories are read once and written once per pixel.
// Reset (synchronous) empties the pipeline, clears counters and window, and sets the frame to
// 600 x 400. Line memories are not cleared; row 0 of each frame writes every entry later read.
module box_blur_3x3_clamped_core (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [bb3_pkg::PixW-1:0]        req_pixel,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [bb3_pkg::BlurW-1:0]      rsp_blurred,
   output logic [bb3_pkg::ColW-1:0]       rsp_out_col,
   output logic [bb3_pkg::RowW-1:0]       rsp_out_row,
   output logic                           rsp_last_of_run,
   output logic                           rsp_end_of_frame,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [bb3_pkg::CsrIndexW-1:0]   csr_index,
   input  wire [bb3_pkg::CsrDataW-1:0]    csr_wdata
);

   import bb3_pkg::*;

   logic [ColW-1:0]        w_last_ff, w_last_in;
   logic [RowW-1:0]        h_last_ff, h_last_in;
   logic [ColW-1:0]        col_ff, col_in;
   logic [RowW-1:0]        row_ff, row_in;
   logic [WidthCfgW-1:0]   width_value;
   logic [HeightCfgW-1:0]  height_value;
   logic                   csr_fire;
   logic                   restart;
   logic                   in_fire;
   item_type               in_item;
   logic                   wr_en;
   logic [ColW-1:0]        wr_addr;
   logic [PixW-1:0]        older_wr_data, newer_wr_data;
   logic [PixW-1:0]        older_rd_data, newer_rd_data;
   logic                   run_valid;
   logic                   run_free;
   run_type                run;

   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid && csr_ready;
   assign restart = csr_fire && ((csr_index == CsrFrameWidth) || (csr_index == CsrFrameHeight));
   assign width_value = csr_wdata[WidthCfgW-1:0];
   assign height_value = csr_wdata[HeightCfgW-1:0];

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_fire && (csr_index == CsrFrameWidth)) begin
         priority if (width_value == '0) begin
            w_last_in = '0;
         end else if (width_value > WidthCfgW'(MaxWidth)) begin
            w_last_in = ColW'(MaxWidth - 1);
         end else begin
            w_last_in = ColW'(width_value - WidthCfgW'(1));
         end
      end
      if (csr_fire && (csr_index == CsrFrameHeight)) begin
         priority if (height_value == '0) begin
            h_last_in = '0;
         end else if (height_value > HeightCfgW'(MaxHeight)) begin
            h_last_in = RowW'(MaxHeight - 1);
         end else begin
            h_last_in = RowW'(height_value - HeightCfgW'(1));
         end
      end
   end

   assign in_fire = req_valid && !req_stall;

   always_comb begin
      in_item.pixel = req_pixel;
      in_item.col = col_ff;
      in_item.row = row_ff;
      in_item.last_col = (col_ff == w_last_ff);
      in_item.last_row = (row_ff == h_last_ff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (in_fire) begin
         if (in_item.last_col) begin
            col_in = '0;
            row_in = in_item.last_row ? '0 : row_ff + RowW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end else begin
         col_in = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= ColW'(WidthReset - 1);
         h_last_ff <= RowW'(HeightReset - 1);
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   bb3_ram #(
      .Width (PixW),
      .Depth (MaxWidth)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (older_wr_data),
      .rd_en   (in_fire),
      .rd_addr (col_ff),
      .rd_data (older_rd_data)
   );

   bb3_ram #(
      .Width (PixW),
      .Depth (MaxWidth)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (newer_wr_data),
      .rd_en   (in_fire),
      .rd_addr (col_ff),
      .rd_data (newer_rd_data)
   );

   bb3_window u_window (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .in_fire       (in_fire),
      .in_item       (in_item),
      .older_rd_data (older_rd_data),
      .newer_rd_data (newer_rd_data),
      .run_free      (run_free),
      .in_stall      (req_stall),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .older_wr_data (older_wr_data),
      .newer_wr_data (newer_wr_data),
      .run_valid     (run_valid),
      .run           (run)
   );

   bb3_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .run_valid        (run_valid),
      .run              (run),
      .run_free         (run_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blurred      (rsp_blurred),
      .rsp_out_col      (rsp_out_col),
      .rsp_out_row      (rsp_out_row),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last_ff)
      else $error("Column counter ran past the frame width.");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last_ff)
      else $error("Row counter ran past the frame height.");

endmodule
`default_nettype wire
